>>> sv/tsfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsfc_pkg
// Shared types and constants of the touch sample filter controller.
// ----------------------------------------------------------------------------
package tsfc_pkg;

	localparam int unsigned SAMPLE_BITS_DEF = 10;
	localparam int unsigned LIMIT_BITS      = 10;
	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 10'd10;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_PEN_IRQ    = 2'd0;
	localparam kind_t KIND_CONVERSION = 2'd1;
	localparam kind_t KIND_TIMER      = 2'd2;

	typedef enum logic [1:0] {
		MODE_WAIT_DOWN = 2'd0,
		MODE_WAIT_UP   = 2'd1,
		MODE_MEASURE   = 2'd2
	} mode_t;

	localparam logic [1:0] LAST_SAMPLE = 2'd3;

endpackage

>>> sv/tsfc_evt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsfc_evt_if
// Event channel: valid/ready with event kind, pen status and X/Y samples.
// ----------------------------------------------------------------------------
interface tsfc_evt_if #(
	parameter int unsigned SAMPLE_BITS = tsfc_pkg::SAMPLE_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	tsfc_pkg::kind_t        kind;
	logic                   pen_up;
	logic [SAMPLE_BITS-1:0] x_sample;
	logic [SAMPLE_BITS-1:0] y_sample;

	modport source (output valid, kind, pen_up, x_sample, y_sample, input ready);
	modport sink   (input valid, kind, pen_up, x_sample, y_sample, output ready);
endinterface

>>> sv/tsfc_rpt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsfc_rpt_if
// Result channel: valid/ready with panel mode, timer request and touch report.
// ----------------------------------------------------------------------------
interface tsfc_rpt_if #(
	parameter int unsigned SAMPLE_BITS = tsfc_pkg::SAMPLE_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	tsfc_pkg::mode_t        next_mode;
	logic                   start_timer;
	logic                   report_valid;
	logic                   pressed;
	logic [SAMPLE_BITS-1:0] x_position;
	logic [SAMPLE_BITS-1:0] y_position;

	modport source (output valid, next_mode, start_timer, report_valid, pressed,
		x_position, y_position, input ready);
	modport sink   (input valid, next_mode, start_timer, report_valid, pressed,
		x_position, y_position, output ready);
endinterface

>>> sv/tsfc_axis_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsfc_axis_check
// Consistency check and four-sample floor mean for one axis.
// ----------------------------------------------------------------------------
module tsfc_axis_check #(
	parameter int unsigned SAMPLE_BITS = tsfc_pkg::SAMPLE_BITS_DEF
) (
	input  logic [SAMPLE_BITS-1:0]          s0,
	input  logic [SAMPLE_BITS-1:0]          s1,
	input  logic [SAMPLE_BITS-1:0]          s2,
	input  logic [SAMPLE_BITS-1:0]          s3,
	input  logic [tsfc_pkg::LIMIT_BITS-1:0] limit,
	output logic                            ok,
	output logic [SAMPLE_BITS-1:0]          mean
);
	localparam int unsigned SB = SAMPLE_BITS;
	localparam int unsigned CW = (SB > tsfc_pkg::LIMIT_BITS) ? SB : tsfc_pkg::LIMIT_BITS;

	logic [SB:0]   sum01, sum12;
	logic [SB-1:0] mean01, mean12;
	logic [SB-1:0] dev2, dev3;
	logic [SB+1:0] sum4;

	always_comb begin
		sum01  = {1'b0, s0} + {1'b0, s1};
		sum12  = {1'b0, s1} + {1'b0, s2};
		mean01 = sum01[SB:1];
		mean12 = sum12[SB:1];
		dev2   = (s2 >= mean01) ? (s2 - mean01) : (mean01 - s2);
		dev3   = (s3 >= mean12) ? (s3 - mean12) : (mean12 - s3);
		ok     = (CW'(dev2) <= CW'(limit)) && (CW'(dev3) <= CW'(limit));
		sum4   = {2'b00, s0} + {2'b00, s1} + {2'b00, s2} + {2'b00, s3};
		mean   = sum4[SB+1:2];
	end
endmodule

>>> sv/touch_sample_filter_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_sample_filter_controller_unit
// Resistive touch panel sample filter: takes pen, conversion and timer
// events, gathers four X/Y samples, checks them and reports the position.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  evt       in         valid/ready        kind, pen_up, x_sample, y_sample
//  rpt       out        valid/ready        next_mode, start_timer, report_valid,
//                                          pressed, x_position, y_position
//  cfg       in         cfg_wr_en          cfg_wr_data (error limit)
//
//  One event per cycle unless the result stalls; each event passes the input
//  register and then the result register, with the filter logic between them.
//  Reset clears the pipeline, the sample count and sets the error limit to 10.
//  A stalled result holds its register; the input register still takes an
//  event until both registers are full.
// ----------------------------------------------------------------------------
module touch_sample_filter_controller_unit #(
	parameter int unsigned SAMPLE_BITS = tsfc_pkg::SAMPLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	tsfc_evt_if.sink                        evt,
	tsfc_rpt_if.source                      rpt,
	input  logic                            cfg_wr_en,
	input  logic [tsfc_pkg::LIMIT_BITS-1:0] cfg_wr_data
);
	localparam int unsigned SB = SAMPLE_BITS;

	logic [tsfc_pkg::LIMIT_BITS-1:0] error_limit_q;
	logic [1:0]                      count_q;
	logic [SB-1:0]                   x_store_q [0:2];
	logic [SB-1:0]                   y_store_q [0:2];

	logic                            valid_s1;
	tsfc_pkg::kind_t                 kind_s1;
	logic                            up_s1;
	logic [SB-1:0]                   x_s1, y_s1;

	logic                            rpt_valid_q;
	tsfc_pkg::mode_t                 mode_q;
	logic                            timer_q, report_q, pressed_q;
	logic [SB-1:0]                   xpos_q, ypos_q;

	logic                            advance;
	logic                            x_ok, y_ok;
	logic [SB-1:0]                   x_mean, y_mean;

	tsfc_pkg::mode_t                 mode_d;
	logic                            timer_d, report_d, pressed_d;
	logic [SB-1:0]                   xpos_d, ypos_d;
	logic [1:0]                      count_d;
	logic                            store_wr;

	assign advance   = !rpt_valid_q || rpt.ready;
	assign evt.ready = !valid_s1 || advance;

	tsfc_axis_check #(.SAMPLE_BITS(SB)) u_x_check (
		.s0    (x_store_q[0]),
		.s1    (x_store_q[1]),
		.s2    (x_store_q[2]),
		.s3    (x_s1),
		.limit (error_limit_q),
		.ok    (x_ok),
		.mean  (x_mean)
	);

	tsfc_axis_check #(.SAMPLE_BITS(SB)) u_y_check (
		.s0    (y_store_q[0]),
		.s1    (y_store_q[1]),
		.s2    (y_store_q[2]),
		.s3    (y_s1),
		.limit (error_limit_q),
		.ok    (y_ok),
		.mean  (y_mean)
	);

	always_comb begin
		mode_d    = tsfc_pkg::MODE_MEASURE;
		timer_d   = 1'b0;
		report_d  = 1'b0;
		pressed_d = 1'b0;
		xpos_d    = '0;
		ypos_d    = '0;
		count_d   = count_q;
		store_wr  = 1'b0;
		if (kind_s1 == tsfc_pkg::KIND_CONVERSION) begin
			if (up_s1) begin
				mode_d  = tsfc_pkg::MODE_WAIT_DOWN;
				count_d = '0;
			end else if (count_q == tsfc_pkg::LAST_SAMPLE) begin
				mode_d  = tsfc_pkg::MODE_WAIT_UP;
				timer_d = 1'b1;
				count_d = '0;
				if (x_ok && y_ok) begin
					report_d  = 1'b1;
					pressed_d = 1'b1;
					xpos_d    = x_mean;
					ypos_d    = y_mean;
				end
			end else begin
				store_wr = 1'b1;
				count_d  = count_q + 2'd1;
			end
		end else if (up_s1) begin
			mode_d   = tsfc_pkg::MODE_WAIT_DOWN;
			report_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_limit_q <= tsfc_pkg::LIMIT_RESET;
			count_q       <= '0;
			valid_s1      <= 1'b0;
			rpt_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				error_limit_q <= cfg_wr_data;
			end
			if (evt.ready) begin
				valid_s1 <= evt.valid;
			end
			if (advance) begin
				rpt_valid_q <= valid_s1;
				if (valid_s1) begin
					count_q <= count_d;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (evt.ready && evt.valid) begin
			kind_s1 <= evt.kind;
			up_s1   <= evt.pen_up;
			x_s1    <= evt.x_sample;
			y_s1    <= evt.y_sample;
		end
		if (advance && valid_s1) begin
			mode_q    <= mode_d;
			timer_q   <= timer_d;
			report_q  <= report_d;
			pressed_q <= pressed_d;
			xpos_q    <= xpos_d;
			ypos_q    <= ypos_d;
			if (store_wr) begin
				x_store_q[count_q] <= x_s1;
				y_store_q[count_q] <= y_s1;
			end
		end
	end

	assign rpt.valid        = rpt_valid_q;
	assign rpt.next_mode    = mode_q;
	assign rpt.start_timer  = timer_q;
	assign rpt.report_valid = report_q;
	assign rpt.pressed      = pressed_q;
	assign rpt.x_position   = xpos_q;
	assign rpt.y_position   = ypos_q;
endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the touch sample filter controller. Pen, timer
// and conversion events go in through a bursty driver; every result is
// checked field by field against an in-bench model of the filter, under
// several error limits, with random receiver stalls and two long hold-offs.
// ----------------------------------------------------------------------------
module testbench;
	import tsfc_pkg::*;

	localparam int unsigned SB        = SAMPLE_BITS_DEF;
	localparam int unsigned SMAX      = (1 << SB) - 1;
	localparam kind_t       KIND_SPARE = 2'd3;
	localparam int unsigned IDLE_LIMIT = 5000;
	localparam int unsigned HOLD_LEN   = 300;
	localparam int unsigned PHASE_ITEMS = 200;

	typedef struct packed {
		kind_t         kind;
		logic          pen_up;
		logic [SB-1:0] x;
		logic [SB-1:0] y;
	} panel_evt_t;

	typedef struct packed {
		mode_t         next_mode;
		logic          start_timer;
		logic          report_valid;
		logic          pressed;
		logic [SB-1:0] x_position;
		logic [SB-1:0] y_position;
	} panel_reply_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [LIMIT_BITS-1:0] cfg_wr_data;

	tsfc_evt_if evt_ch ();
	tsfc_rpt_if rpt_ch ();

	touch_sample_filter_controller_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.evt        (evt_ch),
		.rpt        (rpt_ch),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	panel_evt_t   queued_events[$];
	panel_reply_t awaited_replies[$];

	// model state
	logic [1:0]            smp_cnt;
	logic [SB-1:0]         x_hist[4];
	logic [SB-1:0]         y_hist[4];
	logic [LIMIT_BITS-1:0] model_limit;

	int unsigned errors;
	int unsigned evt_xfers;
	int unsigned rpt_xfers;
	int unsigned touch_reports;
	int unsigned release_reports;
	int unsigned limit_settings;

	function automatic bit near_mean(logic [SB-1:0] a, logic [SB-1:0] b, logic [SB-1:0] c);
		int m;
		int d;
		m = (int'(a) + int'(b)) / 2;
		d = int'(c) - m;
		if (d < 0)
			d = -d;
		return d <= int'(model_limit);
	endfunction

	function automatic bit set_consistent();
		if (!near_mean(x_hist[0], x_hist[1], x_hist[2]) ||
			!near_mean(y_hist[0], y_hist[1], y_hist[2]))
			return 1'b0;
		if (!near_mean(x_hist[1], x_hist[2], x_hist[3]) ||
			!near_mean(y_hist[1], y_hist[2], y_hist[3]))
			return 1'b0;
		return 1'b1;
	endfunction

	function automatic panel_reply_t filter_event(panel_evt_t ev);
		panel_reply_t r;
		r.next_mode    = MODE_MEASURE;
		r.start_timer  = 1'b0;
		r.report_valid = 1'b0;
		r.pressed      = 1'b0;
		r.x_position   = '0;
		r.y_position   = '0;
		if (ev.kind == KIND_CONVERSION) begin
			if (ev.pen_up) begin
				r.next_mode = MODE_WAIT_DOWN;
				smp_cnt = '0;
			end else begin
				x_hist[smp_cnt] = ev.x;
				y_hist[smp_cnt] = ev.y;
				if (smp_cnt == LAST_SAMPLE) begin
					if (set_consistent()) begin
						r.report_valid = 1'b1;
						r.pressed      = 1'b1;
						r.x_position   = SB'((int'(x_hist[0]) + int'(x_hist[1]) +
							int'(x_hist[2]) + int'(x_hist[3])) / 4);
						r.y_position   = SB'((int'(y_hist[0]) + int'(y_hist[1]) +
							int'(y_hist[2]) + int'(y_hist[3])) / 4);
					end
					smp_cnt       = '0;
					r.next_mode   = MODE_WAIT_UP;
					r.start_timer = 1'b1;
				end else begin
					smp_cnt = smp_cnt + 2'd1;
				end
			end
		end else if (ev.pen_up) begin
			r.next_mode    = MODE_WAIT_DOWN;
			r.report_valid = 1'b1;
		end
		return r;
	endfunction

	function automatic void add_evt(kind_t k, logic up, int x, int y);
		panel_evt_t ev;
		ev.kind   = k;
		ev.pen_up = up;
		ev.x      = SB'(x);
		ev.y      = SB'(y);
		queued_events.push_back(ev);
	endfunction

	function automatic int jitter(int base, int spread);
		int v;
		v = base + int'($urandom_range(0, 2 * spread)) - spread;
		if (v < 0)
			v = 0;
		if (v > int'(SMAX))
			v = int'(SMAX);
		return v;
	endfunction

	function automatic kind_t any_trigger();
		case ($urandom_range(0, 3))
			0: return KIND_PEN_IRQ;
			1: return KIND_TIMER;
			2: return KIND_SPARE;
			default: return KIND_PEN_IRQ;
		endcase
	endfunction

	// one touch: pen down, one or more sample sets, then pen up
	function automatic int add_touch();
		int bx;
		int by;
		int spread;
		int sets;
		int n;
		n  = 0;
		bx = $urandom_range(0, SMAX);
		by = $urandom_range(0, SMAX);
		if ($urandom_range(0, 4) == 0)
			spread = $urandom_range(0, SMAX);
		else
			spread = $urandom_range(0, int'(model_limit) + 4);
		sets = $urandom_range(1, 3);
		add_evt(any_trigger(), 1'b0, $urandom_range(0, SMAX), $urandom_range(0, SMAX));
		n++;
		for (int s = 0; s < sets; s++) begin
			for (int i = 0; i < 4; i++) begin
				if ($urandom_range(0, 15) == 0) begin
					add_evt(KIND_CONVERSION, 1'b1, $urandom_range(0, SMAX),
						$urandom_range(0, SMAX));
					n++;
				end
				add_evt(KIND_CONVERSION, 1'b0, jitter(bx, spread), jitter(by, spread));
				n++;
			end
			if (s < sets - 1) begin
				add_evt(any_trigger(), 1'b0, $urandom_range(0, SMAX),
					$urandom_range(0, SMAX));
				n++;
			end
		end
		add_evt(any_trigger(), 1'b1, $urandom_range(0, SMAX), $urandom_range(0, SMAX));
		n++;
		return n;
	endfunction

	task automatic fill_random(int unsigned count);
		int unsigned added;
		int unsigned noise;
		added = 0;
		while (added < count) begin
			if ($urandom_range(0, 6) != 0) begin
				added += add_touch();
			end else begin
				noise = $urandom_range(1, 5);
				for (int i = 0; i < noise; i++)
					add_evt(kind_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
						$urandom_range(0, SMAX), $urandom_range(0, SMAX));
				added += noise;
			end
		end
	endtask

	task automatic wait_drained();
		while (queued_events.size() != 0 || evt_ch.valid || awaited_replies.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(logic [LIMIT_BITS-1:0] v);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		model_limit = v;
		limit_settings++;
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// driver: bursts of transfers separated by random gaps
	int unsigned burst_left;
	int unsigned gap_left;

	always @(posedge clk or negedge arst_n) begin
		panel_evt_t ev;
		logic       take;
		logic       nv;
		if (!arst_n) begin
			evt_ch.valid <= 1'b0;
			burst_left   = 1;
			gap_left     = 0;
		end else begin
			take = evt_ch.valid && evt_ch.ready;
			if (take) begin
				ev = queued_events.pop_front();
				awaited_replies.push_back(filter_event(ev));
				evt_xfers++;
			end
			if (evt_ch.valid && !take) begin
				nv = 1'b1;
			end else if (gap_left > 0) begin
				nv = 1'b0;
				gap_left--;
			end else if (queued_events.size() != 0) begin
				nv = 1'b1;
				evt_ch.kind     <= queued_events[0].kind;
				evt_ch.pen_up   <= queued_events[0].pen_up;
				evt_ch.x_sample <= queued_events[0].x;
				evt_ch.y_sample <= queued_events[0].y;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 40);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end else begin
				nv = 1'b0;
			end
			evt_ch.valid <= nv;
		end
	end

	// receiver: changing stall patterns plus two long hold-offs
	int unsigned hold_left;
	int unsigned holds_done;
	int unsigned pat_left;
	int unsigned pat_mode;
	int unsigned pat_cyc;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpt_ch.ready <= 1'b0;
			hold_left  = 0;
			holds_done = 0;
			pat_left   = 0;
			pat_mode   = 0;
			pat_cyc    = 0;
		end else begin
			pat_cyc++;
			if (hold_left > 0) begin
				hold_left--;
				rpt_ch.ready <= 1'b0;
			end else if (holds_done < 2 && evt_xfers >= 200 + holds_done * 600) begin
				hold_left = HOLD_LEN;
				holds_done++;
				rpt_ch.ready <= 1'b0;
			end else begin
				if (pat_left == 0) begin
					pat_mode = $urandom_range(0, 3);
					pat_left = $urandom_range(20, 200);
				end else begin
					pat_left--;
				end
				case (pat_mode)
					0: rpt_ch.ready <= 1'b1;
					1: rpt_ch.ready <= 1'($urandom_range(0, 1));
					2: rpt_ch.ready <= ($urandom_range(0, 4) != 0);
					default: rpt_ch.ready <= ((pat_cyc % 5) < 2);
				endcase
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		panel_reply_t e;
		if (arst_n && rpt_ch.valid && rpt_ch.ready) begin
			rpt_xfers++;
			if (awaited_replies.size() == 0) begin
				$error("unexpected result: mode %0d report %0b", rpt_ch.next_mode,
					rpt_ch.report_valid);
				errors++;
			end else begin
				e = awaited_replies.pop_front();
				if (e.report_valid && e.pressed)
					touch_reports++;
				if (e.report_valid && !e.pressed)
					release_reports++;
				if (rpt_ch.next_mode !== e.next_mode) begin
					$error("next_mode: expected %0d, actual %0d", e.next_mode,
						rpt_ch.next_mode);
					errors++;
				end
				if (rpt_ch.start_timer !== e.start_timer) begin
					$error("start_timer: expected %0b, actual %0b", e.start_timer,
						rpt_ch.start_timer);
					errors++;
				end
				if (rpt_ch.report_valid !== e.report_valid) begin
					$error("report_valid: expected %0b, actual %0b", e.report_valid,
						rpt_ch.report_valid);
					errors++;
				end
				if (rpt_ch.pressed !== e.pressed) begin
					$error("pressed: expected %0b, actual %0b", e.pressed, rpt_ch.pressed);
					errors++;
				end
				if (rpt_ch.x_position !== e.x_position) begin
					$error("x_position: expected %0d, actual %0d", e.x_position,
						rpt_ch.x_position);
					errors++;
				end
				if (rpt_ch.y_position !== e.y_position) begin
					$error("y_position: expected %0d, actual %0d", e.y_position,
						rpt_ch.y_position);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	int unsigned idle_cycles;

	always @(posedge clk) begin
		if (!arst_n || (evt_ch.valid && evt_ch.ready) || (rpt_ch.valid && rpt_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: %0d results outstanding", awaited_replies.size());
			$display("testbench failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n          = 1'b0;
		cfg_wr_en       = 1'b0;
		cfg_wr_data     = '0;
		evt_ch.valid    = 1'b0;
		evt_ch.kind     = KIND_PEN_IRQ;
		evt_ch.pen_up   = 1'b0;
		evt_ch.x_sample = '0;
		evt_ch.y_sample = '0;
		rpt_ch.ready    = 1'b0;
		idle_cycles     = 0;
		errors          = 0;
		evt_xfers       = 0;
		rpt_xfers       = 0;
		touch_reports   = 0;
		release_reports = 0;
		limit_settings  = 1;
		smp_cnt         = '0;
		model_limit     = LIMIT_RESET;
		for (int i = 0; i < 4; i++) begin
			x_hist[i] = '0;
			y_hist[i] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset error limit
		add_evt(KIND_PEN_IRQ, 1'b1, 0, 0);
		add_evt(KIND_PEN_IRQ, 1'b0, SMAX, SMAX);
		add_evt(KIND_TIMER, 1'b1, SMAX, 0);
		add_evt(KIND_TIMER, 1'b0, 0, SMAX);
		add_evt(KIND_SPARE, 1'b1, 0, 0);
		add_evt(KIND_SPARE, 1'b0, 0, 0);
		add_evt(KIND_CONVERSION, 1'b0, 300, 300);
		add_evt(KIND_CONVERSION, 1'b0, 301, 301);
		add_evt(KIND_CONVERSION, 1'b1, 302, 302);
		for (int i = 0; i < 4; i++)
			add_evt(KIND_CONVERSION, 1'b0, 0, 0);
		for (int i = 0; i < 4; i++)
			add_evt(KIND_CONVERSION, 1'b0, SMAX, SMAX);
		// deviation exactly at the limit on both checks
		add_evt(KIND_CONVERSION, 1'b0, 100, 500);
		add_evt(KIND_CONVERSION, 1'b0, 101, 500);
		add_evt(KIND_CONVERSION, 1'b0, 110, 500);
		add_evt(KIND_CONVERSION, 1'b0, 95, 500);
		// one past the limit on Y
		add_evt(KIND_CONVERSION, 1'b0, 200, 500);
		add_evt(KIND_CONVERSION, 1'b0, 200, 501);
		add_evt(KIND_CONVERSION, 1'b0, 200, 511);
		add_evt(KIND_CONVERSION, 1'b0, 200, 505);
		fill_random(PHASE_ITEMS);
		wait_drained();

		write_limit('0);
		fill_random(PHASE_ITEMS);
		wait_drained();

		write_limit(LIMIT_BITS'(SMAX));
		fill_random(PHASE_ITEMS);
		wait_drained();

		write_limit(LIMIT_BITS'($urandom_range(1, 30)));
		fill_random(PHASE_ITEMS);
		wait_drained();

		write_limit(LIMIT_BITS'($urandom_range(0, SMAX)));
		fill_random(PHASE_ITEMS);
		wait_drained();

		write_limit(LIMIT_RESET);
		fill_random(PHASE_ITEMS);
		wait_drained();
		repeat (8) @(posedge clk);

		$display("%0d events, %0d results checked under %0d error limits",
			evt_xfers, rpt_xfers, limit_settings);
		$display("%0d position reports, %0d release reports", touch_reports,
			release_reports);
		if (errors == 0 && awaited_replies.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
